[design/vobp_pkg.sv]
// Shared types and constants of the voxel occupancy block pool.
// No dependencies; every other design file imports this package.
package vobp_pkg;

  localparam int unsigned CellW  = 6;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned LogitW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_SIZE  = 2'd0,
    CFG_OUT_SIZE   = 2'd1,
    CFG_BLOCK_SIZE = 2'd2
  } cfg_reg_e;

  // Control that travels with a sample from the counters to the pooling stage.
  typedef struct packed {
    logic             in_range;
    logic             first;
    logic             done;
    logic             final_smp;
    logic [CellW-1:0] cell_x;
    logic [CellW-1:0] cell_y;
    logic [CellW-1:0] cell_z;
  } smp_ctl_t;

endpackage

[design/voxel_occupancy_block_pool_core.sv]
// An accepted sample is held in the stage-1 registers; its result enters the output register when stage 1 advances.
// Throughput: one sample per cycle while the output register is not stalled, set by the single
// read-modify-write of one occupancy bit per sample with forwarding between neighboring samples.
// Reset clears counters and valid flags and sets the configuration to 64/16/4; the occupancy
// memory is not cleared, as the first sample of each block overwrites its bit.
module voxel_occupancy_block_pool_core #(
  parameter int unsigned MAX_GRID = 64,
  parameter int unsigned MAX_OUT  = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [vobp_pkg::LogitW-1:0] logit_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [vobp_pkg::CellW-1:0]         cell_x_o,
  output logic [vobp_pkg::CellW-1:0]         cell_y_o,
  output logic [vobp_pkg::CellW-1:0]         cell_z_o,
  output logic                               active_o,
  output logic                               end_of_list_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vobp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [vobp_pkg::CfgW-1:0]          cfg_data_i
);
  import vobp_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_GRID);
  localparam int unsigned CW   = $clog2(MAX_OUT + 1);
  localparam int unsigned IdxW = ($clog2(MAX_OUT * MAX_OUT) > 0) ?
                                 $clog2(MAX_OUT * MAX_OUT) : 1;

  logic [CfgW-1:0] grid_q;
  logic [CfgW-1:0] outsz_q;
  logic [CfgW-1:0] block_q;
  int unsigned     g_eff;
  int unsigned     o_eff;
  int unsigned     b_eff;
  logic [PW-1:0]   g_m1;
  logic [PW-1:0]   b_m1;
  logic [CW-1:0]   o_lim;
  logic            accept;
  logic            busy;
  smp_ctl_t        ctl;
  logic [IdxW-1:0] idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= CfgW'(64);
      outsz_q <= CfgW'(16);
      block_q <= CfgW'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_SIZE:  grid_q  <= cfg_data_i;
        CFG_OUT_SIZE:   outsz_q <= cfg_data_i;
        CFG_BLOCK_SIZE: block_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, values past the limit act as the limit
  always_comb begin
    g_eff = (grid_q == '0) ? 1 :
            ((32'(grid_q) > MAX_GRID) ? MAX_GRID : 32'(grid_q));
    o_eff = (outsz_q == '0) ? 1 :
            ((32'(outsz_q) > MAX_OUT) ? MAX_OUT : 32'(outsz_q));
    b_eff = (block_q == '0) ? 1 :
            ((32'(block_q) > MAX_GRID) ? MAX_GRID : 32'(block_q));
    g_m1  = PW'(g_eff - 1);
    b_m1  = PW'(b_eff - 1);
    o_lim = CW'(o_eff);
  end

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  vobp_seq #(
    .MAX_GRID (MAX_GRID),
    .MAX_OUT  (MAX_OUT),
    .PW       (PW),
    .CW       (CW),
    .IdxW     (IdxW)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .g_m1_i (g_m1),
    .b_m1_i (b_m1),
    .o_i    (o_lim),
    .ctl_o  (ctl),
    .idx_o  (idx)
  );

  vobp_pool #(
    .MAX_OUT (MAX_OUT),
    .Depth   (MAX_OUT * MAX_OUT),
    .IdxW    (IdxW)
  ) u_pool (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .logit_i       (logit_i),
    .ctl_i         (ctl),
    .idx_i         (idx),
    .busy_o        (busy),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .cell_z_o      (cell_z_o),
    .active_o      (active_o),
    .end_of_list_o (end_of_list_o)
  );

`ifndef NO_ASSERTIONS
  a_cell_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_list_o |-> active_o)
    else $error("cell result without active bit");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result register can drain");

  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_o |->
      (32'(cell_x_o) < o_eff) && (32'(cell_y_o) < o_eff) && (32'(cell_z_o) < o_eff))
    else $error("active cell outside coarse grid");
`endif

endmodule

[design/vobp_seq.sv]
// Sample position, in-block offset and coarse cell counters of the grid scan.
// Depends on vobp_pkg for the sample control struct.
module vobp_seq #(
  parameter int unsigned MAX_GRID = 64,
  parameter int unsigned MAX_OUT  = 64,
  parameter int unsigned PW       = $clog2(MAX_GRID),
  parameter int unsigned CW       = $clog2(MAX_OUT + 1),
  parameter int unsigned IdxW     = ($clog2(MAX_OUT * MAX_OUT) > 0) ?
                                    $clog2(MAX_OUT * MAX_OUT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [PW-1:0]      g_m1_i,
  input  logic [PW-1:0]      b_m1_i,
  input  logic [CW-1:0]      o_i,
  output vobp_pkg::smp_ctl_t ctl_o,
  output logic [IdxW-1:0]    idx_o
);
  import vobp_pkg::*;

  // lane 0 is x, 1 is y, 2 is z
  logic [PW-1:0] pos_q [3];
  logic [PW-1:0] pos_d [3];
  logic [PW-1:0] off_q [3];
  logic [PW-1:0] off_d [3];
  logic [CW-1:0] cnt_q [3];
  logic [CW-1:0] cnt_d [3];
  logic [2:0]    wrap;
  logic [2:0]    step;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wrap[a] = (pos_q[a] >= g_m1_i);
    end
    step[2] = adv_i;
    step[1] = adv_i && wrap[2];
    step[0] = adv_i && wrap[2] && wrap[1];
    for (int a = 0; a < 3; a++) begin
      pos_d[a] = pos_q[a];
      off_d[a] = off_q[a];
      cnt_d[a] = cnt_q[a];
      if (step[a]) begin
        if (wrap[a]) begin
          pos_d[a] = '0;
          off_d[a] = '0;
          cnt_d[a] = '0;
        end else begin
          pos_d[a] = pos_q[a] + PW'(1);
          if (off_q[a] >= b_m1_i) begin
            off_d[a] = '0;
            if (cnt_q[a] < o_i) begin
              cnt_d[a] = cnt_q[a] + CW'(1);
            end
          end else begin
            off_d[a] = off_q[a] + PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        pos_q[a] <= '0;
        off_q[a] <= '0;
        cnt_q[a] <= '0;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        pos_q[a] <= pos_d[a];
        off_q[a] <= off_d[a];
        cnt_q[a] <= cnt_d[a];
      end
    end
  end

  always_comb begin
    ctl_o.in_range  = (cnt_q[0] < o_i) && (cnt_q[1] < o_i) && (cnt_q[2] < o_i);
    ctl_o.first     = (off_q[0] == '0) && (off_q[1] == '0) && (off_q[2] == '0);
    ctl_o.done      = (off_q[0] == b_m1_i) && (off_q[1] == b_m1_i) &&
                      (off_q[2] == b_m1_i);
    ctl_o.final_smp = wrap[0] && wrap[1] && wrap[2];
    ctl_o.cell_x    = CellW'(cnt_q[0]);
    ctl_o.cell_y    = CellW'(cnt_q[1]);
    ctl_o.cell_z    = CellW'(cnt_q[2]);
    // row per cell_y, column per cell_z
    idx_o = IdxW'(IdxW'(cnt_q[1]) * IdxW'(MAX_OUT) + IdxW'(cnt_q[2]));
  end

endmodule

[design/vobp_pool.sv]
// Occupancy bit memory with read-modify-write, one-deep forwarding and the
// result register. Depends on vobp_pkg for the sample control struct.
module vobp_pool #(
  parameter int unsigned MAX_OUT = 64,
  parameter int unsigned Depth   = MAX_OUT * MAX_OUT,
  parameter int unsigned IdxW    = ($clog2(MAX_OUT * MAX_OUT) > 0) ?
                                   $clog2(MAX_OUT * MAX_OUT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [vobp_pkg::LogitW-1:0] logit_i,
  input  vobp_pkg::smp_ctl_t            ctl_i,
  input  logic [IdxW-1:0]               idx_i,
  output logic                          busy_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [vobp_pkg::CellW-1:0]    cell_x_o,
  output logic [vobp_pkg::CellW-1:0]    cell_y_o,
  output logic [vobp_pkg::CellW-1:0]    cell_z_o,
  output logic                          active_o,
  output logic                          end_of_list_o
);
  import vobp_pkg::*;

  logic            or_mem_q [Depth];
  logic            rd_q;
  logic            s1_valid_q;
  smp_ctl_t        s1_ctl_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_occ_q;
  logic            fwd_q;
  logic            fwd_bit_q;
  logic            s1_adv;
  logic            bit_new;
  logic            show;
  logic            has_out;
  logic            out_valid_q;
  logic            out_valid_d;
  logic [CellW-1:0] cell_x_q;
  logic [CellW-1:0] cell_y_q;
  logic [CellW-1:0] cell_z_q;
  logic            active_q;
  logic            eol_q;

  always_comb begin
    s1_adv  = s1_valid_q && (!out_valid_q || !out_stall_i);
    busy_o  = s1_valid_q && !s1_adv;
    // first sample of a block overwrites the stored bit
    bit_new = s1_ctl_q.first ? s1_occ_q :
              ((fwd_q ? fwd_bit_q : rd_q) || s1_occ_q);
    show    = s1_ctl_q.in_range && s1_ctl_q.done;
    has_out = (show && bit_new) || s1_ctl_q.final_smp;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = has_out;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_ctl_q.in_range) begin
      or_mem_q[s1_idx_q] <= bit_new;
    end
    if (accept_i) begin
      rd_q <= or_mem_q[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept_i) begin
        s1_valid_q <= 1'b1;
        // the write of the leaving sample lands at this same edge
        fwd_q      <= s1_adv && s1_ctl_q.in_range && (s1_idx_q == idx_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_ctl_q  <= ctl_i;
      s1_idx_q  <= idx_i;
      s1_occ_q  <= (logit_i != '0) && !logit_i[LogitW-1];
      fwd_bit_q <= bit_new;
    end
    if (s1_adv && has_out) begin
      cell_x_q <= show ? s1_ctl_q.cell_x : '0;
      cell_y_q <= show ? s1_ctl_q.cell_y : '0;
      cell_z_q <= show ? s1_ctl_q.cell_z : '0;
      active_q <= show && bit_new;
      eol_q    <= s1_ctl_q.final_smp;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_x_o      = cell_x_q;
  assign cell_y_o      = cell_y_q;
  assign cell_z_o      = cell_z_q;
  assign active_o      = active_q;
  assign end_of_list_o = eol_q;

endmodule

[test/vobp_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the voxel occupancy block pool: predicts the cell list from accepted samples.
// Depends on vobp_pkg for widths and register codes.
package vobp_tb_pkg;
  import vobp_pkg::*;

  localparam int unsigned TbMaxGrid = 64;
  localparam int unsigned TbMaxOut  = 64;

  typedef struct packed {
    logic [CellW-1:0] x;
    logic [CellW-1:0] y;
    logic [CellW-1:0] z;
    logic             active;
    logic             eol;
  } cell_item_t;

  class cell_list_scoreboard;
    bit [CfgW-1:0]  grid_reg;
    bit [CfgW-1:0]  out_reg;
    bit [CfgW-1:0]  blk_reg;
    // axis 0 is x, 1 is y, 2 is z
    bit [CellW-1:0] pos [3];
    bit [CellW-1:0] off [3];
    bit [CfgW-1:0]  cnt [3];
    bit             or_bits [TbMaxOut*TbMaxOut];
    cell_item_t     cells_due [$];
    int unsigned    failures;

    function new();
      grid_reg = 7'd64;
      out_reg  = 7'd16;
      blk_reg  = 7'd4;
      foreach (pos[a]) begin
        pos[a] = '0;
        off[a] = '0;
        cnt[a] = '0;
      end
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [CfgW-1:0] value);
      case (idx)
        CFG_GRID_SIZE:  grid_reg = value;
        CFG_OUT_SIZE:   out_reg  = value;
        CFG_BLOCK_SIZE: blk_reg  = value;
        default: ;
      endcase
    endfunction

    function int unsigned clamped(bit [CfgW-1:0] value, int unsigned hi);
      if (value == 0) return 1;
      return (value > hi) ? hi : value;
    endfunction

    function bit at_origin();
      return pos[0] == 0 && pos[1] == 0 && pos[2] == 0;
    endfunction

    // Step one axis; return 1 when it wraps and carries into the next.
    function bit advance(int a, int unsigned g, int unsigned b, int unsigned o);
      if (pos[a] >= g - 1) begin
        pos[a] = '0;
        off[a] = '0;
        cnt[a] = '0;
        return 1'b1;
      end
      pos[a] = pos[a] + 1'b1;
      if (off[a] >= b - 1) begin
        off[a] = '0;
        if (cnt[a] < o) cnt[a] = cnt[a] + 1'b1;
      end else begin
        off[a] = off[a] + 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_sample(logic signed [LogitW-1:0] logit);
      int unsigned g, o, b, slot;
      bit occ, or_now, done, first, final_smp;
      cell_item_t item;
      g = clamped(grid_reg, TbMaxGrid);
      o = clamped(out_reg, TbMaxOut);
      b = clamped(blk_reg, TbMaxGrid);
      occ = logit > 0;
      final_smp = pos[0] >= g - 1 && pos[1] >= g - 1 && pos[2] >= g - 1;
      or_now = 1'b0;
      done = 1'b0;
      if (cnt[0] < o && cnt[1] < o && cnt[2] < o) begin
        slot = cnt[1] * TbMaxOut + cnt[2];
        first = off[0] == 0 && off[1] == 0 && off[2] == 0;
        // the first sample of a block overwrites the running OR
        or_now = first ? occ : (or_bits[slot] | occ);
        or_bits[slot] = or_now;
        done = off[0] == b - 1 && off[1] == b - 1 && off[2] == b - 1;
      end
      if ((done && or_now) || final_smp) begin
        item.x      = done ? cnt[0][CellW-1:0] : '0;
        item.y      = done ? cnt[1][CellW-1:0] : '0;
        item.z      = done ? cnt[2][CellW-1:0] : '0;
        item.active = done && or_now;
        item.eol    = final_smp;
        cells_due = {cells_due, item};
      end
      if (advance(2, g, b, o))
        if (advance(1, g, b, o))
          void'(advance(0, g, b, o));
    endfunction

    function void match_cell(cell_item_t got);
      cell_item_t want;
      if (cells_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected cell x=%0d y=%0d z=%0d active=%0b eol=%0b",
                   got.x, got.y, got.z, got.active, got.eol);
        return;
      end
      want = cells_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.active !== want.active || got.eol !== want.eol) begin
        failures++;
        if (failures <= 10)
          $display("cell mismatch: expected x=%0d y=%0d z=%0d active=%0b eol=%0b, %s",
                   want.x, want.y, want.z, want.active, want.eol,
                   $sformatf("got x=%0d y=%0d z=%0d active=%0b eol=%0b",
                             got.x, got.y, got.z, got.active, got.eol));
      end
    endfunction
  endclass

endpackage

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the voxel occupancy block pool testbench: clock, reset, sample, config and back-pressure drivers.
// Depends on vobp_pkg, vobp_tb_pkg and voxel_occupancy_block_pool_core.
module testbench;
  import vobp_pkg::*;
  import vobp_tb_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [LogitW-1:0] logit;
  logic                     out_valid;
  logic                     out_stall;
  logic [CellW-1:0]         cell_x;
  logic [CellW-1:0]         cell_y;
  logic [CellW-1:0]         cell_z;
  logic                     active;
  logic                     end_of_list;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index;
  logic [CfgW-1:0]          cfg_data;

  bit quiet;
  bit long_hold_req;

  cell_list_scoreboard sb;

  voxel_occupancy_block_pool_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .logit_i      (logit),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cell_x_o     (cell_x),
    .cell_y_o     (cell_y),
    .cell_z_o     (cell_z),
    .active_o     (active),
    .end_of_list_o(end_of_list),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic signed [LogitW-1:0] pick_logit(int unsigned pct);
    int unsigned r;
    r = $urandom_range(0, 7);
    if ($urandom_range(0, 99) < pct) begin
      case (r)
        0: return 16'sh0001;
        1: return 16'sh7FFF;
        default: return {1'b0, 15'($urandom_range(1, 32767))};
      endcase
    end
    case (r)
      0, 1: return 16'sh0000;
      2: return 16'sh8000;
      3: return 16'shFFFF;
      default: return {1'b1, 15'($urandom)};
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_cell({cell_x, cell_y, cell_z, active, end_of_list});
  end

  // Receiver back-pressure, with one long hold on request.
  initial begin
    int stall_left, free_left;
    out_stall = 1'b0;
    stall_left = 0;
    free_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (quiet || free_left > 0) begin
        out_stall = 1'b0;
        if (free_left > 0) free_left--;
      end else begin
        out_stall = 1'b0;
        free_left = $urandom_range(0, 8);
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_sample(input logic signed [LogitW-1:0] value);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    logit = value;
    do @(posedge clk); while (in_stall);
    sb.take_sample(value);
  endtask

  // Drop valid, wait for every pending cell, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [CfgW-1:0] g, input logic [CfgW-1:0] o,
                            input logic [CfgW-1:0] b);
    drain();
    cfg_write(CFG_GRID_SIZE, g);
    cfg_write(CFG_OUT_SIZE, o);
    cfg_write(CFG_BLOCK_SIZE, b);
  endtask

  // A grid of one sample wraps every axis, so one sample returns the stream to the origin.
  task automatic rewind_grid(input logic [CfgW-1:0] g);
    drain();
    cfg_write(CFG_GRID_SIZE, g);
    send_sample(pick_logit(50));
    drain();
  endtask

  initial begin
    int unsigned g, o, b, count, pct, random_items, vol;
    int phase;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    logit = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_SIZE;
    cfg_data = '0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // logit extremes at the reset configuration, then shrink the grid mid-stream
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh0100);
    rewind_grid(7'd0);

    // one 2x2x2 block per grid; the second grid must not inherit the first one's OR
    set_config(7'd2, 7'd1, 7'd2);
    send_sample(-16'sd5);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd300);
    send_sample(16'sh0000);
    send_sample(-16'sd2);
    send_sample(16'sh0000);
    send_sample(-16'sd7);
    repeat (8) send_sample(pick_logit(0));

    // zero and oversized registers; blocks larger than the grid never complete
    set_config(7'd0, 7'd0, 7'd127);
    send_sample(16'sh0042);
    send_sample(16'sh8001);

    random_items = 0;
    phase = 0;
    while (random_items < 1850) begin
      pct = 25;
      case ($urandom_range(0, 3))
        0: pct = 3;
        1: pct = 25;
        2: pct = 60;
        default: pct = 95;
      endcase
      case (phase)
        0: begin g = 64;  o = 64;  b = 1;   count = 200; pct = 95; end
        1: begin g = 127; o = 1;   b = 64;  count = 150; end
        2: begin g = 100; o = 100; b = 127; count = 120; end
        3: begin g = 1;   o = 1;   b = 1;   count = 20;  end
        4: begin g = 0;   o = 0;   b = 0;   count = 12;  end
        default: begin
          g = $urandom_range(1, 9);
          b = $urandom_range(1, 4);
          o = $urandom_range(1, g / b + 2);
          vol = g * g * g;
          count = (vol <= 300) ? vol * $urandom_range(1, 3) : vol;
        end
      endcase
      if (count > 1850 - random_items) count = 1850 - random_items;
      set_config(CfgW'(g), CfgW'(o), CfgW'(b));
      quiet = (phase % 5 == 4);
      for (int i = 0; i < count; i++) begin
        if (phase == 0 && i == 20) long_hold_req = 1'b1;
        if (phase == 5 && i == count / 2) drain();
        send_sample(pick_logit(pct));
        random_items++;
      end
      drain();
      if (!sb.at_origin()) rewind_grid(CfgW'($urandom_range(0, 1)));
      quiet = 1'b0;
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.cells_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/vobp_pkg.sv
design/vobp_seq.sv
design/vobp_pool.sv
design/voxel_occupancy_block_pool_core.sv
test/vobp_tb_pkg.sv
test/testbench.sv
